// ===== sv/q8ec_pkg.sv =====
// Shared types and constants for the eight-node quadrilateral connectivity block.
// Used by q8ec_div_cell, q8ec_node_stage and quad8_element_connectivity.
// No dependencies.
`default_nettype none
package q8ec_pkg;
	localparam int DIM_W     = 11;
	localparam int DIM_MAX   = 2047;
	localparam int ELEM_W    = 20;
	localparam int NODE_W    = 22;
	localparam int CALC_W    = 24;
	localparam int CFG_IDX_W = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COLUMNS  = 2'd0,
		REG_ROWS     = 2'd1,
		REG_PERIODIC = 2'd2
	} cfg_reg_t;

	// Request travelling down the divider chain
	typedef struct packed {
		logic [ELEM_W-1:0] elem;
		logic [ELEM_W-1:0] quo;
		logic [DIM_W-1:0]  rem;
	} div_data_t;

	// Grid geometry and derived block bases
	typedef struct packed {
		logic [DIM_W-1:0]  nx;
		logic [DIM_W-1:0]  ny;
		logic              periodic;
		logic [CALC_W-1:0] cells;
		logic [CALC_W-1:0] ccount;
		logic [CALC_W-1:0] vbase;
	} grid_t;
endpackage
`default_nettype wire

// ===== sv/quad8_element_connectivity.sv =====
// Eight-node quadrilateral element connectivity, top level. Depends on q8ec_pkg,
// q8ec_div_cell and q8ec_node_stage.
//
// Takes one element number per request and returns its eight node numbers (corners
// counter-clockwise from bottom left, then mid-sides bottom, right, top, left) and
// an out-of-range flag. One request is accepted every cycle while the output side
// keeps up; each result passes through the row of 20 restoring divider cells (one
// quotient bit each, the first loaded at acceptance) and then the node register.
// Empty cells close up, so a stalled result does not block new requests until the
// chain is full. Register writes pass through the register file and then the cells,
// ccount and vbase registers before reaching the derived node bases, and must only
// be made while no request is in flight.
`default_nettype none
module quad8_element_connectivity #(
	parameter int MAX_DIM = 1024
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [q8ec_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [q8ec_pkg::DIM_W-1:0]          cfg_data,
	input  wire logic                                in_valid,
	output      logic                                in_ready,
	input  wire logic [q8ec_pkg::ELEM_W-1:0]         element_number,
	output      logic                                out_valid,
	input  wire logic                                out_ready,
	output      logic [q8ec_pkg::NODE_W-1:0]         corner_bottom_left,
	output      logic [q8ec_pkg::NODE_W-1:0]         corner_bottom_right,
	output      logic [q8ec_pkg::NODE_W-1:0]         corner_top_right,
	output      logic [q8ec_pkg::NODE_W-1:0]         corner_top_left,
	output      logic [q8ec_pkg::NODE_W-1:0]         mid_bottom,
	output      logic [q8ec_pkg::NODE_W-1:0]         mid_right,
	output      logic [q8ec_pkg::NODE_W-1:0]         mid_top,
	output      logic [q8ec_pkg::NODE_W-1:0]         mid_left,
	output      logic                                out_of_range
);
	localparam int DW      = q8ec_pkg::DIM_W;
	localparam int CW      = q8ec_pkg::CALC_W;
	localparam int NW      = q8ec_pkg::NODE_W;
	localparam int NCELL   = q8ec_pkg::ELEM_W;
	localparam int CAP_INT = (MAX_DIM > q8ec_pkg::DIM_MAX) ? q8ec_pkg::DIM_MAX : MAX_DIM;
	localparam logic [DW-1:0] DIM_CAP = CAP_INT[DW-1:0];

	function automatic logic [DW-1:0] clamp_dim(input logic [DW-1:0] v);
		logic [DW-1:0] r;
		r = v;
		if (v == '0) begin
			r = DW'(1);
		end else if (v > DIM_CAP) begin
			r = DIM_CAP;
		end
		return r;
	endfunction

	logic [DW-1:0]          columns_q, rows_q;
	logic                   periodic_q;
	logic [DW-1:0]          nx, ny;
	logic [2*DW-1:0]        prod;
	logic [CW-1:0]          cells_q, ccount_q, vbase_q;
	q8ec_pkg::grid_t        grid;

	logic                   cv [NCELL+1];
	logic                   cr [NCELL+1];
	q8ec_pkg::div_data_t    cd [NCELL+1];
	logic [NW-1:0]          nodes [8];

	// Register writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			columns_q  <= DW'(1);
			rows_q     <= DW'(1);
			periodic_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				q8ec_pkg::REG_COLUMNS:  columns_q  <= cfg_data;
				q8ec_pkg::REG_ROWS:     rows_q     <= cfg_data;
				q8ec_pkg::REG_PERIODIC: periodic_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Clamp dimensions and derive the node block bases
	assign nx   = clamp_dim(columns_q);
	assign ny   = clamp_dim(rows_q);
	assign prod = nx * ny;

	always_ff @(posedge clk) begin
		cells_q  <= CW'(prod);
		ccount_q <= cells_q + CW'(nx) + CW'(ny) + CW'(1);
		vbase_q  <= ccount_q + cells_q + CW'(nx);
	end

	always_comb begin
		grid.nx       = nx;
		grid.ny       = ny;
		grid.periodic = periodic_q;
		grid.cells    = cells_q;
		grid.ccount   = ccount_q;
		grid.vbase    = vbase_q;
	end

	// Feed the divider chain
	assign cv[0]      = in_valid;
	assign in_ready   = cr[0];
	assign cd[0].elem = element_number;
	assign cd[0].quo  = '0;
	assign cd[0].rem  = '0;

	for (genvar k = 0; k < NCELL; k++) begin : g_cell
		q8ec_div_cell #(
			.BIT(NCELL - 1 - k)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.divisor   (nx),
			.in_valid  (cv[k]),
			.in_ready  (cr[k]),
			.in_data   (cd[k]),
			.out_valid (cv[k+1]),
			.out_ready (cr[k+1]),
			.out_data  (cd[k+1])
		);
	end

	q8ec_node_stage u_nodes (
		.clk          (clk),
		.arst_n       (arst_n),
		.grid         (grid),
		.in_valid     (cv[NCELL]),
		.in_ready     (cr[NCELL]),
		.in_data      (cd[NCELL]),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.nodes        (nodes),
		.out_of_range (out_of_range)
	);

	assign corner_bottom_left  = nodes[0];
	assign corner_bottom_right = nodes[1];
	assign corner_top_right    = nodes[2];
	assign corner_top_left     = nodes[3];
	assign mid_bottom          = nodes[4];
	assign mid_right           = nodes[5];
	assign mid_top             = nodes[6];
	assign mid_left            = nodes[7];

	// An accepted request lands in the first cell
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> cv[1])
		else $error("accepted request lost at chain entry");

	// A request waiting at the chain end is not dropped
	a_tail_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cv[NCELL] && !cr[NCELL] |=> cv[NCELL])
		else $error("request dropped at chain end");

	// A result past the grid carries no node numbers
	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_of_range |-> corner_bottom_left == '0 && corner_top_right == '0
			&& mid_bottom == '0 && mid_left == '0)
		else $error("out-of-range result has non-zero nodes");
endmodule
`default_nettype wire

// ===== sv/q8ec_div_cell.sv =====
// One cell of the restoring divider chain: resolves one quotient bit per request.
// Depends on q8ec_pkg.
`default_nettype none
module q8ec_div_cell #(
	parameter int BIT = 0
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [q8ec_pkg::DIM_W-1:0]    divisor,
	input  wire logic                          in_valid,
	output      logic                          in_ready,
	input  wire q8ec_pkg::div_data_t           in_data,
	output      logic                          out_valid,
	input  wire logic                          out_ready,
	output      q8ec_pkg::div_data_t           out_data
);
	localparam int DW = q8ec_pkg::DIM_W;

	logic                 valid_q;
	q8ec_pkg::div_data_t  data_q;
	logic [DW:0]          trial;
	logic [DW:0]          diff;
	logic                 ge;
	q8ec_pkg::div_data_t  data_next;

	// Take a new request when empty or when the neighbour takes ours
	assign in_ready = !valid_q || out_ready;

	// Shift in the next dividend bit and try the subtraction
	always_comb begin
		trial          = {in_data.rem, in_data.elem[BIT]};
		diff           = trial - {1'b0, divisor};
		ge             = trial >= {1'b0, divisor};
		data_next.elem = in_data.elem;
		data_next.quo  = {in_data.quo[q8ec_pkg::ELEM_W-2:0], ge};
		data_next.rem  = ge ? diff[DW-1:0] : trial[DW-1:0];
	end

	// Hold occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	// Advance the request payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_q <= data_next;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;
endmodule
`default_nettype wire

// ===== sv/q8ec_node_stage.sv =====
// Final cell: turns quotient and remainder into the eight node numbers and holds
// the result for the output channel. Depends on q8ec_pkg.
`default_nettype none
module q8ec_node_stage (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire q8ec_pkg::grid_t              grid,
	input  wire logic                         in_valid,
	output      logic                         in_ready,
	input  wire q8ec_pkg::div_data_t          in_data,
	output      logic                         out_valid,
	input  wire logic                         out_ready,
	output      logic [q8ec_pkg::NODE_W-1:0]  nodes [8],
	output      logic                         out_of_range
);
	localparam int CW = q8ec_pkg::CALC_W;
	localparam int NW = q8ec_pkg::NODE_W;
	localparam int DW = q8ec_pkg::DIM_W;

	logic          valid_q;
	logic [NW-1:0] nodes_q [8];
	logic          oor_q;

	logic [CW-1:0] ez, jz, iz, nxz, nyz;
	logic [CW-1:0] rowb, i1, base, up, n [8];
	logic [DW-1:0] nxm1;
	logic          oor, lastcol, lastrow;

	assign in_ready = !valid_q || out_ready;

	// Work out node numbers; open mode uses j*(nx+1)+i = e+j
	always_comb begin
		ez      = CW'(in_data.elem);
		jz      = CW'(in_data.quo);
		iz      = CW'(in_data.rem);
		nxz     = CW'(grid.nx);
		nyz     = CW'(grid.ny);
		nxm1    = grid.nx - DW'(1);
		oor     = jz >= nyz;
		lastcol = in_data.rem == nxm1;
		lastrow = jz == nyz - CW'(1);
		rowb    = ez - iz;
		i1      = lastcol ? '0 : iz + CW'(1);
		base    = ez + jz;
		up      = ez + nxz;
		if (grid.periodic) begin
			n[0] = ez;
			n[1] = lastcol ? rowb : ez + CW'(1);
			n[2] = lastrow ? i1 : (lastcol ? rowb + nxz : up + CW'(1));
			n[3] = lastrow ? iz : up;
			n[4] = grid.cells + ez;
			n[5] = {grid.cells[CW-2:0], 1'b0} + n[1];
			n[6] = grid.cells + n[3];
			n[7] = {grid.cells[CW-2:0], 1'b0} + ez;
		end else begin
			n[0] = base;
			n[1] = base + CW'(1);
			n[2] = base + nxz + CW'(2);
			n[3] = base + nxz + CW'(1);
			n[4] = grid.ccount + ez;
			n[5] = grid.vbase + base + CW'(1);
			n[6] = grid.ccount + up;
			n[7] = grid.vbase + base;
		end
	end

	// Hold occupancy of the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	// Load the result; zero the nodes past the grid
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			oor_q <= oor;
			for (int k = 0; k < 8; k++) begin
				nodes_q[k] <= oor ? '0 : n[k][NW-1:0];
			end
		end
	end

	assign out_valid    = valid_q;
	assign out_of_range = oor_q;
	always_comb begin
		for (int k = 0; k < 8; k++) begin
			nodes[k] = nodes_q[k];
		end
	end
endmodule
`default_nettype wire

// ===== verif/quad8_element_connectivity_checker.sv =====
// Checker for the eight-node quadrilateral connectivity block: tracks register
// writes, predicts the node numbers of every accepted request and compares results.
// Depends on q8ec_pkg.
module quad8_element_connectivity_checker
	import q8ec_pkg::*;
#(
	parameter int MAX_DIM = 1024
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [DIM_W-1:0]     cfg_data,
	input  wire logic                 in_valid,
	input  wire logic                 in_ready,
	input  wire logic [ELEM_W-1:0]    element_number,
	input  wire logic                 out_valid,
	input  wire logic                 out_ready,
	input  wire logic [NODE_W-1:0]    corner_bottom_left,
	input  wire logic [NODE_W-1:0]    corner_bottom_right,
	input  wire logic [NODE_W-1:0]    corner_top_right,
	input  wire logic [NODE_W-1:0]    corner_top_left,
	input  wire logic [NODE_W-1:0]    mid_bottom,
	input  wire logic [NODE_W-1:0]    mid_right,
	input  wire logic [NODE_W-1:0]    mid_top,
	input  wire logic [NODE_W-1:0]    mid_left,
	input  wire logic                 out_of_range,
	output int                        fail_count,
	output int                        pending
);
	timeunit 1ns;
	timeprecision 1ps;

	// Eight node numbers, corners first, then mid-sides bottom, right, top, left
	typedef struct packed {
		logic [7:0][NODE_W-1:0] node;
		logic                   out_of_range;
	} node_set_t;

	logic [DIM_W-1:0] columns_q;
	logic [DIM_W-1:0] rows_q;
	logic             periodic_q;
	node_set_t        expected_nodes [$];
	node_set_t        oldest;

	wire node_set_t seen = {mid_left, mid_top, mid_right, mid_bottom, corner_top_left,
		corner_top_right, corner_bottom_right, corner_bottom_left, out_of_range};

	function automatic string node_name(input int k);
		case (k)
			0: return "corner_bottom_left";
			1: return "corner_bottom_right";
			2: return "corner_top_right";
			3: return "corner_top_left";
			4: return "mid_bottom";
			5: return "mid_right";
			6: return "mid_top";
			default: return "mid_left";
		endcase
	endfunction

	// A zero dimension counts as one; anything past MAX_DIM saturates
	function automatic longint unsigned dim_in_use(input logic [DIM_W-1:0] v);
		if (v == 0) return 1;
		if (v > MAX_DIM) return MAX_DIM;
		return v;
	endfunction

	function automatic node_set_t element_nodes(input logic [ELEM_W-1:0] elem);
		longint unsigned nx, ny, e, i, j, i1, j1, cells, w, ccount, vbase;
		longint unsigned n [8];
		node_set_t r;
		nx = dim_in_use(columns_q);
		ny = dim_in_use(rows_q);
		e = elem;
		r = '0;
		// Past the grid: flag it and leave every node at zero
		if (e >= nx * ny) begin
			r.out_of_range = 1'b1;
			return r;
		end
		i = e % nx;
		j = e / nx;
		if (periodic_q) begin
			// Last row and column wrap onto the first
			cells = nx * ny;
			i1 = (i + 1 == nx) ? 0 : i + 1;
			j1 = (j + 1 == ny) ? 0 : j + 1;
			n[0] = j * nx + i;
			n[1] = j * nx + i1;
			n[2] = j1 * nx + i1;
			n[3] = j1 * nx + i;
			n[4] = cells + j * nx + i;
			n[5] = 2 * cells + j * nx + i1;
			n[6] = cells + j1 * nx + i;
			n[7] = 2 * cells + j * nx + i;
		end else begin
			// Corners, then horizontal mids, then vertical mids
			w = nx + 1;
			ccount = w * (ny + 1);
			vbase = ccount + nx * (ny + 1);
			n[0] = j * w + i;
			n[1] = j * w + i + 1;
			n[2] = (j + 1) * w + i + 1;
			n[3] = (j + 1) * w + i;
			n[4] = ccount + j * nx + i;
			n[5] = vbase + j * w + i + 1;
			n[6] = ccount + (j + 1) * nx + i;
			n[7] = vbase + j * w + i;
		end
		for (int k = 0; k < 8; k++) r.node[k] = n[k][NODE_W-1:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			columns_q <= 1;
			rows_q <= 1;
			periodic_q <= 1'b0;
			expected_nodes.delete();
			pending <= 0;
		end else begin
			// Match each result against the oldest outstanding request
			if (out_valid && out_ready) begin
				if (expected_nodes.size() == 0) begin
					$error("result with no request outstanding");
					fail_count++;
				end else begin
					oldest = expected_nodes.pop_front();
					for (int k = 0; k < 8; k++) begin
						if (seen.node[k] !== oldest.node[k]) begin
							$error("%s: expected %0d, got %0d", node_name(k),
								oldest.node[k], seen.node[k]);
							fail_count++;
						end
					end
					if (seen.out_of_range !== oldest.out_of_range) begin
						$error("out_of_range: expected %0d, got %0d",
							oldest.out_of_range, seen.out_of_range);
						fail_count++;
					end
				end
			end
			// Predict every accepted request
			if (in_valid && in_ready)
				expected_nodes.push_back(element_nodes(element_number));
			// Track register writes; unknown indexes are dropped
			if (cfg_we) begin
				case (cfg_index)
					REG_COLUMNS: columns_q <= cfg_data;
					REG_ROWS: rows_q <= cfg_data;
					REG_PERIODIC: periodic_q <= cfg_data[0];
					default: ;
				endcase
			end
			pending <= expected_nodes.size();
		end
	end
endmodule

// ===== verif/quad8_element_connectivity_test.sv =====
// Test top for quad8_element_connectivity: clock, reset, register setup and request
// and result traffic across several grids; the checker does the comparing.
// Depends on q8ec_pkg, quad8_element_connectivity and quad8_element_connectivity_checker.
module quad8_element_connectivity_test;
	timeunit 1ns;
	timeprecision 1ps;
	import q8ec_pkg::*;

	localparam int MAX_DIM = 1024;
	localparam int unsigned ELEM_TOP = (1 << ELEM_W) - 1;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
	localparam int SETTLE_CYCLES = 4;
	localparam int DRAIN_CYCLES = 24;
	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_GRIDS = 9;
	localparam int GRID_REQUESTS = 150;
	localparam int STALL_CYCLES = 300;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [DIM_W-1:0]     cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [ELEM_W-1:0]    element_number = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [NODE_W-1:0]    corner_bottom_left;
	logic [NODE_W-1:0]    corner_bottom_right;
	logic [NODE_W-1:0]    corner_top_right;
	logic [NODE_W-1:0]    corner_top_left;
	logic [NODE_W-1:0]    mid_bottom;
	logic [NODE_W-1:0]    mid_right;
	logic [NODE_W-1:0]    mid_top;
	logic [NODE_W-1:0]    mid_left;
	logic                 out_of_range;
	int                   fail_count;
	int                   pending;

	int          send_idle_pct = 14;
	int          recv_idle_pct = 51;
	int          stall_request = 0;
	int unsigned grid_nx = 1;
	int unsigned grid_ny = 1;

	quad8_element_connectivity #(.MAX_DIM(MAX_DIM)) u_top (.*);

	quad8_element_connectivity_checker #(.MAX_DIM(MAX_DIM)) u_checker (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic int unsigned grid_dim(input logic [DIM_W-1:0] v);
		if (v == 0) return 1;
		if (v > MAX_DIM) return MAX_DIM;
		return v;
	endfunction

	// Mostly ordinary sizes, a few small ones, now and then zero or oversize
	function automatic logic [DIM_W-1:0] random_dim();
		int unsigned sel;
		sel = $urandom_range(9);
		if (sel == 0) return 0;
		if (sel == 1) return DIM_W'($urandom_range(DIM_MAX, MAX_DIM + 1));
		if (sel < 5) return DIM_W'($urandom_range(8, 1));
		return DIM_W'($urandom_range(MAX_DIM, 1));
	endfunction

	// Mostly elements inside the grid, with edge columns and rows and some strays
	function automatic int unsigned pick_element();
		int unsigned cells, sel;
		cells = grid_nx * grid_ny;
		sel = $urandom_range(19);
		if (sel < 3) return $urandom_range(ELEM_TOP);
		if (sel == 3) return $urandom_range(grid_ny - 1) * grid_nx + grid_nx - 1;
		if (sel == 4) return (grid_ny - 1) * grid_nx + $urandom_range(grid_nx - 1);
		if (sel == 5 && cells <= ELEM_TOP) return cells;
		return $urandom_range(cells - 1);
	endfunction

	// Offer one request, with an optional gap first, and hold it until taken
	task automatic send_element(input int unsigned e);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		element_number <= e[ELEM_W-1:0];
		do @(posedge clk); while (!in_ready);
	endtask

	// Stop offering and wait until every outstanding result is back
	task automatic drain_requests();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	// Reprogram the grid while idle; the spare index must leave it untouched
	task automatic set_grid(input logic [DIM_W-1:0] cols, input logic [DIM_W-1:0] rws,
			input logic [DIM_W-1:0] mode_word);
		drain_requests();
		write_reg(REG_COLUMNS, cols);
		write_reg(REG_ROWS, rws);
		write_reg(REG_PERIODIC, mode_word);
		write_reg(REG_SPARE, DIM_W'($urandom_range(DIM_MAX)));
		cfg_we <= 1'b0;
		repeat (SETTLE_CYCLES) @(posedge clk);
		grid_nx = grid_dim(cols);
		grid_ny = grid_dim(rws);
	endtask

	// Result side: random back-pressure, plus one long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (stall_request != 0) begin
				out_ready <= 1'b0;
				for (int c = 0; c < stall_request; c++) @(posedge clk);
				stall_request = 0;
			end
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	initial begin
		for (int c = 0; c < CYCLE_LIMIT; c++) @(posedge clk);
		$display("status: fail");
		$finish;
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Small open grid: every element, the first one past it and the top code
		set_grid(3, 2, 0);
		for (int e = 0; e <= 6; e++) send_element(e);
		send_element(ELEM_TOP);
		// Same grid wrapped, including the last column and last row
		set_grid(3, 2, 1);
		send_element(0);
		send_element(2);
		send_element(3);
		send_element(5);
		// Zero dimensions behave as one
		set_grid(0, 0, 0);
		send_element(0);
		send_element(1);
		// Oversize dimensions saturate; wrapped at full size
		set_grid(DIM_MAX, DIM_MAX, 1);
		send_element(0);
		send_element(MAX_DIM - 1);
		send_element(MAX_DIM);
		send_element(ELEM_TOP);
		// Full open grid, largest node numbers; only bit 0 selects the mode
		set_grid(MAX_DIM, MAX_DIM, DIM_MAX - 1);
		send_element(0);
		send_element(ELEM_TOP);
		send_element(ELEM_TOP - MAX_DIM + 1);

		// Random grids through the three idling regimes
		for (int g = 0; g < RANDOM_GRIDS; g++) begin
			set_grid(random_dim(), random_dim(), DIM_W'($urandom_range(DIM_MAX)));
			if (g == 3) begin
				send_idle_pct = 51;
				recv_idle_pct = 14;
			end
			if (g == 6) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
				stall_request = STALL_CYCLES;
			end
			repeat (GRID_REQUESTS) send_element(pick_element());
		end

		drain_requests();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
